/* sv/cfr_pkg.sv */
// Shared types, codes and defaults of the checksummed frame receiver.
`timescale 1ns / 1ps

package cfr_pkg;

   // Default width of the idle tick counter.
   localparam int TICK_COUNT_BITS_DEFAULT = 16;

   // Configuration register widths and reset values.
   localparam int          CSR_DATA_BITS          = 16;
   localparam int          CSR_INDEX_BITS         = 2;
   localparam logic [7:0]  START_BYTE_RESET       = 8'hFC;
   localparam logic [15:0] TIMEOUT_TICKS_RESET    = 16'd1000;
   localparam logic [7:0]  MAX_LENGTH_RESET       = 8'd26;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_BYTE    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TIMEOUT_TICKS = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_LENGTH    = 2'd2;

   // Input word kinds.
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // Role of a frame byte in a result word.
   typedef enum logic [2:0] {
      ROLE_COMMAND   = 3'd0,
      ROLE_HEADER0   = 3'd1,
      ROLE_HEADER1   = 3'd2,
      ROLE_LENGTH    = 3'd3,
      ROLE_PAYLOAD   = 3'd4,
      ROLE_FRAME_END = 3'd5
   } role_type;

   // Frame status in a result word.
   typedef enum logic [2:0] {
      STATUS_IN_PROGRESS = 3'd0,
      STATUS_GOOD        = 3'd1,
      STATUS_BAD_SUM     = 3'd2,
      STATUS_TIMEOUT     = 3'd3,
      STATUS_TOO_LONG    = 3'd4
   } status_type;

   // Current configuration as seen by the deframer.
   typedef struct packed {
      logic [7:0]  start_byte;
      logic [15:0] timeout_ticks;
      logic [7:0]  max_length;
   } cfg_type;

   // One result word.
   typedef struct packed {
      role_type   role;
      logic [7:0] byte_value;
      logic [7:0] payload_index;
      status_type status;
      logic       last;
   } result_type;

endpackage

/* sv/checksummed_frame_receiver_core.sv */
// Top level of the checksummed frame receiver: configuration registers and deframer.
`timescale 1ns / 1ps

// Takes one word per cycle, either a received serial byte or one time tick, and
// gives at most one result word for it in the next cycle from a single result
// register. A word is taken in every cycle unless that register holds a result
// that is stalled, so the sustained rate is one word per clock. The block hunts
// for the start byte, then reports the command, both header bytes, the length,
// every payload byte with its position and finally the checksum byte with a good
// or bad status; a length above max_length closes the frame at once with a
// too-long status, and an open frame that sees timeout_ticks ticks without a byte
// closes with a timeout status. Configuration registers are written through the
// csr_ port and take effect on the next word.
module checksummed_frame_receiver_core #(
   parameter int TICK_COUNT_BITS = cfr_pkg::TICK_COUNT_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [cfr_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [cfr_pkg::CSR_DATA_BITS-1:0]  csr_write_data,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_opcode,
   input  logic [7:0]                         req_rx_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [2:0]                         rsp_role,
   output logic [7:0]                         rsp_byte_value,
   output logic [7:0]                         rsp_payload_index,
   output logic [2:0]                         rsp_status,
   output logic                               rsp_last
);

   cfr_pkg::cfg_type    cfg_ff, cfg_in;
   cfr_pkg::result_type result;

   // Configuration register writes; unknown indexes are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            cfr_pkg::CSR_START_BYTE:    cfg_in.start_byte    = csr_write_data[7:0];
            cfr_pkg::CSR_TIMEOUT_TICKS: cfg_in.timeout_ticks = csr_write_data[15:0];
            cfr_pkg::CSR_MAX_LENGTH:    cfg_in.max_length    = csr_write_data[7:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_byte    <= cfr_pkg::START_BYTE_RESET;
         cfg_ff.timeout_ticks <= cfr_pkg::TIMEOUT_TICKS_RESET;
         cfg_ff.max_length    <= cfr_pkg::MAX_LENGTH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cfr_deframer #(
      .TICK_COUNT_BITS (TICK_COUNT_BITS)
   ) u_deframer (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_opcode  (req_opcode),
      .req_rx_byte (req_rx_byte),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_result  (result)
   );

   // Result word fields.
   assign rsp_role          = result.role;
   assign rsp_byte_value    = result.byte_value;
   assign rsp_payload_index = result.payload_index;
   assign rsp_status        = result.status;
   assign rsp_last          = result.last;

endmodule

/* sv/cfr_deframer.sv */
// Frame state machine and result register of the checksummed frame receiver.
`timescale 1ns / 1ps

module cfr_deframer #(
   parameter int TICK_COUNT_BITS = cfr_pkg::TICK_COUNT_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  cfr_pkg::cfg_type    cfg,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_opcode,
   input  logic [7:0]          req_rx_byte,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output cfr_pkg::result_type rsp_result
);

   // Compare width that holds both the tick counter and the timeout register.
   localparam int CMP_BITS = (TICK_COUNT_BITS > 16) ? TICK_COUNT_BITS : 16;

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_CMD,
      PH_HDR0,
      PH_HDR1,
      PH_LEN,
      PH_PAY,
      PH_SUM
   } phase_type;

   phase_type                  phase_ff, phase_in;
   logic [7:0]                 bytes_left_ff, bytes_left_in;
   logic [7:0]                 position_ff, position_in;
   logic [7:0]                 sum_ff, sum_in;
   logic [TICK_COUNT_BITS-1:0] idle_ff, idle_in;
   logic [TICK_COUNT_BITS-1:0] idle_step;
   logic                       rsp_valid_ff, rsp_valid_in;
   cfr_pkg::result_type        result_ff, result_in;
   logic                       result_load;
   logic                       accept;
   logic [7:0]                 sum_next;
   logic [7:0]                 expected_sum;

   // The result register frees up whenever its word is taken in this cycle.
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   // Saturating increment of the idle counter.
   assign idle_step = (idle_ff == {TICK_COUNT_BITS{1'b1}}) ? idle_ff
                                                            : idle_ff + 1'b1;
   assign sum_next     = sum_ff + req_rx_byte;
   assign expected_sum = 8'h00 - sum_ff;

   // Next state and result word for one accepted input word.
   always_comb begin
      phase_in      = phase_ff;
      bytes_left_in = bytes_left_ff;
      position_in   = position_ff;
      sum_in        = sum_ff;
      idle_in       = idle_ff;
      result_load   = 1'b0;
      result_in     = '0;
      if (accept) begin
         if (req_opcode == cfr_pkg::OP_TICK) begin
            if (phase_ff != PH_HUNT) begin
               idle_in = idle_step;
               if (CMP_BITS'(idle_step) >= CMP_BITS'(cfg.timeout_ticks)) begin
                  phase_in             = PH_HUNT;
                  bytes_left_in        = '0;
                  position_in          = '0;
                  sum_in               = '0;
                  idle_in              = '0;
                  result_load          = 1'b1;
                  result_in.role       = cfr_pkg::ROLE_FRAME_END;
                  result_in.status     = cfr_pkg::STATUS_TIMEOUT;
                  result_in.last       = 1'b1;
               end
            end
         end else begin
            idle_in              = '0;
            result_in.byte_value = req_rx_byte;
            unique case (phase_ff)
               PH_HUNT: begin
                  if (req_rx_byte == cfg.start_byte) begin
                     phase_in = PH_CMD;
                  end
               end
               PH_CMD: begin
                  sum_in         = sum_next;
                  phase_in       = PH_HDR0;
                  result_load    = 1'b1;
                  result_in.role = cfr_pkg::ROLE_COMMAND;
               end
               PH_HDR0: begin
                  sum_in         = sum_next;
                  phase_in       = PH_HDR1;
                  result_load    = 1'b1;
                  result_in.role = cfr_pkg::ROLE_HEADER0;
               end
               PH_HDR1: begin
                  sum_in         = sum_next;
                  phase_in       = PH_LEN;
                  result_load    = 1'b1;
                  result_in.role = cfr_pkg::ROLE_HEADER1;
               end
               PH_LEN: begin
                  result_load    = 1'b1;
                  result_in.role = cfr_pkg::ROLE_LENGTH;
                  if (req_rx_byte > cfg.max_length) begin
                     // Oversized frame: report it and go back to hunting.
                     phase_in         = PH_HUNT;
                     bytes_left_in    = '0;
                     position_in      = '0;
                     sum_in           = '0;
                     result_in.status = cfr_pkg::STATUS_TOO_LONG;
                     result_in.last   = 1'b1;
                  end else begin
                     sum_in        = sum_next;
                     bytes_left_in = req_rx_byte;
                     position_in   = '0;
                     phase_in      = (req_rx_byte == 8'd0) ? PH_SUM : PH_PAY;
                  end
               end
               PH_PAY: begin
                  sum_in                  = sum_next;
                  result_load             = 1'b1;
                  result_in.role          = cfr_pkg::ROLE_PAYLOAD;
                  result_in.payload_index = position_ff;
                  position_in             = position_ff + 8'd1;
                  bytes_left_in           = bytes_left_ff - 8'd1;
                  if (bytes_left_ff == 8'd1) begin
                     phase_in = PH_SUM;
                  end
               end
               PH_SUM: begin
                  phase_in         = PH_HUNT;
                  bytes_left_in    = '0;
                  position_in      = '0;
                  sum_in           = '0;
                  result_load      = 1'b1;
                  result_in.role   = cfr_pkg::ROLE_FRAME_END;
                  result_in.last   = 1'b1;
                  result_in.status = (expected_sum == req_rx_byte) ?
                                     cfr_pkg::STATUS_GOOD : cfr_pkg::STATUS_BAD_SUM;
               end
               default: begin
                  phase_in = PH_HUNT;
               end
            endcase
         end
      end
   end

   // The output word stays until taken unless a new result replaces it.
   always_comb begin
      if (result_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Frame state and output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT;
         bytes_left_ff <= '0;
         position_ff   <= '0;
         sum_ff        <= '0;
         idle_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         bytes_left_ff <= bytes_left_in;
         position_ff   <= position_in;
         sum_ff        <= sum_in;
         idle_ff       <= idle_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Result payload register.
   always_ff @(posedge clock) begin
      if (result_load) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = result_ff;

endmodule
